FILE: rtl/clfr_pkg.sv
// Shared types and constants for the circular log frame reader.
package clfr_pkg;

    // Configuration register indexes
    localparam logic REG_BEGIN_MARK = 1'b0;
    localparam logic REG_END_MARK   = 1'b1;

    // Reset values of the mark registers
    localparam logic [7:0] BEGIN_MARK_RST = 8'd254;
    localparam logic [7:0] END_MARK_RST   = 8'd255;

    // Request function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_OPEN  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WR,
        ST_SKIP_REQ,
        ST_SKIP_EVAL,
        ST_FWD_REQ,
        ST_FWD_EVAL,
        ST_FWD_ESC_REQ,
        ST_FWD_ESC_EVAL,
        ST_FWD_DONE,
        ST_BWD_REQ,
        ST_BWD_EVAL,
        ST_BWD_ESC_REQ,
        ST_BWD_ESC_EVAL,
        ST_RD_REQ,
        ST_RD_EVAL,
        ST_RD_ESC,
        ST_FIN,
        ST_RESP
    } ctrl_state_t;

    // Memory read address select
    typedef enum logic [1:0] {
        RS_POS,
        RS_POS_DEC,
        RS_RPOS,
        RS_RPOS_INC
    } rd_sel_t;

    // Scan position update
    typedef enum logic [1:0] {
        PO_HOLD,
        PO_ZERO,
        PO_INC,
        PO_DEC
    } pos_op_t;

    // Scan step counter update
    typedef enum logic [1:0] {
        SO_HOLD,
        SO_ZERO,
        SO_INC
    } steps_op_t;

    typedef struct packed {
        logic      accept;
        logic      rd_en;
        rd_sel_t   rd_sel;
        pos_op_t   pos_op;
        steps_op_t steps_op;
        logic      save_byte;
        logic      set_end_pos;
        logic      set_found;
        logic      set_fail;
        logic      rpos_inc;
        logic      wa_sub;
        logic      mem_we;
        logic      res_load_eq;
        logic      res_load_byte;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic steps_ge_m;
        logic steps_gt_m;
        logic rdata_is_end;
        logic rdata_is_begin;
        logic rpos_eq_end;
        logic wa_in_range;
        logic esc_match;
    } dp_status_t;

endpackage

FILE: rtl/clfr_dpath.sv
// Datapath: image memory, scan and read positions, marks and result registers.
module clfr_dpath #(
    parameter int MEM_SIZE = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic [9:0]          s_addr,
    input  logic [7:0]          s_wdata,
    input  clfr_pkg::dp_cmd_t   cmd,
    output clfr_pkg::dp_status_t status,
    output logic [7:0]          m_data,
    output logic                m_at_end,
    output logic [9:0]          m_start_position
);

    localparam int PW = $clog2(MEM_SIZE);
    localparam int SW = PW + 2;
    localparam int WW = (PW > 10) ? PW : 10;
    localparam logic [PW-1:0] LAST_POS   = PW'(MEM_SIZE - 1);
    localparam logic [SW-1:0] MEM_SIZE_S = SW'(MEM_SIZE);
    localparam logic [WW:0]   MEM_SIZE_W = (WW + 1)'(MEM_SIZE);

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
        ring_inc = (p == LAST_POS) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
        ring_dec = (p == '0) ? LAST_POS : p - PW'(1);
    endfunction

    logic [7:0]    mem [MEM_SIZE];
    logic [7:0]    rdata_reg;
    logic [PW-1:0] rd_addr;

    logic [7:0]    begin_mark_reg;
    logic [7:0]    end_mark_reg;
    logic [PW-1:0] pos_reg;
    logic [SW-1:0] steps_reg;
    logic [PW-1:0] read_pos_reg;
    logic [PW-1:0] end_pos_reg;
    logic [PW-1:0] start_pos_reg;
    logic [7:0]    byte_reg;
    logic [WW-1:0] wa_reg;
    logic [7:0]    wdata_reg;
    logic [7:0]    res_data_reg;
    logic          res_end_reg;
    logic [7:0]    m_data_reg;
    logic          m_at_end_reg;
    logic [9:0]    m_start_reg;
    logic [WW-1:0] start_ext;

    always_comb begin
        unique case (cmd.rd_sel)
            clfr_pkg::RS_POS:      rd_addr = pos_reg;
            clfr_pkg::RS_POS_DEC:  rd_addr = ring_dec(pos_reg);
            clfr_pkg::RS_RPOS:     rd_addr = read_pos_reg;
            clfr_pkg::RS_RPOS_INC: rd_addr = ring_inc(read_pos_reg);
            default:               rd_addr = pos_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[wa_reg[PW-1:0]] <= wdata_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Configuration marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_mark_reg <= clfr_pkg::BEGIN_MARK_RST;
            end_mark_reg   <= clfr_pkg::END_MARK_RST;
        end else if (cfg_we) begin
            if (cfg_index == clfr_pkg::REG_BEGIN_MARK) begin
                begin_mark_reg <= cfg_wdata;
            end else begin
                end_mark_reg <= cfg_wdata;
            end
        end
    end

    // Record positions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_pos_reg  <= '0;
            end_pos_reg   <= '0;
            start_pos_reg <= '0;
        end else begin
            if (cmd.set_end_pos) begin
                end_pos_reg <= ring_dec(pos_reg);
            end
            if (cmd.set_found) begin
                start_pos_reg <= pos_reg;
                read_pos_reg  <= ring_inc(pos_reg);
            end else if (cmd.set_fail) begin
                start_pos_reg <= '0;
                read_pos_reg  <= ring_inc('0);
            end else if (cmd.rpos_inc) begin
                read_pos_reg <= ring_inc(read_pos_reg);
            end
        end
    end

    // Scan state, request fields and result holding
    always_ff @(posedge aclk) begin
        unique case (cmd.pos_op)
            clfr_pkg::PO_ZERO: pos_reg <= '0;
            clfr_pkg::PO_INC:  pos_reg <= ring_inc(pos_reg);
            clfr_pkg::PO_DEC:  pos_reg <= ring_dec(pos_reg);
            default:           pos_reg <= pos_reg;
        endcase
        unique case (cmd.steps_op)
            clfr_pkg::SO_ZERO: steps_reg <= '0;
            clfr_pkg::SO_INC:  steps_reg <= steps_reg + SW'(1);
            default:           steps_reg <= steps_reg;
        endcase
        if (cmd.save_byte) begin
            byte_reg <= rdata_reg;
        end
        if (cmd.accept) begin
            wa_reg    <= WW'(s_addr);
            wdata_reg <= s_wdata;
        end else if (cmd.wa_sub) begin
            wa_reg <= wa_reg - MEM_SIZE_W[WW-1:0];
        end
        if (cmd.res_load_eq) begin
            res_data_reg <= '0;
            res_end_reg  <= (read_pos_reg == end_pos_reg);
        end else if (cmd.res_load_byte) begin
            res_data_reg <= byte_reg;
            res_end_reg  <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg   <= res_data_reg;
            m_at_end_reg <= res_end_reg;
            m_start_reg  <= start_ext[9:0];
        end
    end

    assign start_ext = WW'(start_pos_reg);

    assign status.steps_ge_m     = (steps_reg >= MEM_SIZE_S);
    assign status.steps_gt_m     = (steps_reg > MEM_SIZE_S);
    assign status.rdata_is_end   = (rdata_reg == end_mark_reg);
    assign status.rdata_is_begin = (rdata_reg == begin_mark_reg);
    assign status.rpos_eq_end    = (read_pos_reg == end_pos_reg);
    assign status.wa_in_range    = ({1'b0, wa_reg} < MEM_SIZE_W);
    assign status.esc_match      = ((byte_reg == begin_mark_reg) && (rdata_reg == begin_mark_reg))
                                || ((byte_reg == end_mark_reg) && (rdata_reg == end_mark_reg));

    assign m_data           = m_data_reg;
    assign m_at_end         = m_at_end_reg;
    assign m_start_position = m_start_reg;

endmodule

FILE: rtl/clfr_ctrl.sv
// Controller: sequences writes, record location scans, reads and result delivery.
module clfr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_func,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  clfr_pkg::dp_status_t status,
    output clfr_pkg::dp_cmd_t    cmd
);

    clfr_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= clfr_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            clfr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (s_func)
                        clfr_pkg::FUNC_WRITE: state_next = clfr_pkg::ST_WR;
                        clfr_pkg::FUNC_OPEN: begin
                            cmd.pos_op   = clfr_pkg::PO_ZERO;
                            cmd.steps_op = clfr_pkg::SO_ZERO;
                            state_next   = clfr_pkg::ST_SKIP_REQ;
                        end
                        clfr_pkg::FUNC_READ: state_next = clfr_pkg::ST_RD_REQ;
                        default:             state_next = clfr_pkg::ST_FIN;
                    endcase
                end
            end
            clfr_pkg::ST_WR: begin
                if (status.wa_in_range) begin
                    cmd.mem_we = 1'b1;
                    state_next = clfr_pkg::ST_FIN;
                end else begin
                    cmd.wa_sub = 1'b1;
                end
            end
            clfr_pkg::ST_SKIP_REQ: begin
                if (status.steps_ge_m) begin
                    cmd.steps_op = clfr_pkg::SO_ZERO;
                    state_next   = clfr_pkg::ST_FWD_REQ;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = clfr_pkg::RS_POS;
                    state_next = clfr_pkg::ST_SKIP_EVAL;
                end
            end
            clfr_pkg::ST_SKIP_EVAL: begin
                if (status.rdata_is_end) begin
                    cmd.pos_op   = clfr_pkg::PO_INC;
                    cmd.steps_op = clfr_pkg::SO_INC;
                    state_next   = clfr_pkg::ST_SKIP_REQ;
                end else begin
                    cmd.steps_op = clfr_pkg::SO_ZERO;
                    state_next   = clfr_pkg::ST_FWD_REQ;
                end
            end
            clfr_pkg::ST_FWD_REQ: begin
                if (status.steps_gt_m) begin
                    state_next = clfr_pkg::ST_FWD_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = clfr_pkg::RS_POS;
                    state_next = clfr_pkg::ST_FWD_EVAL;
                end
            end
            clfr_pkg::ST_FWD_EVAL: begin
                cmd.pos_op   = clfr_pkg::PO_INC;
                cmd.steps_op = clfr_pkg::SO_INC;
                state_next   = status.rdata_is_end ? clfr_pkg::ST_FWD_ESC_REQ
                                                   : clfr_pkg::ST_FWD_REQ;
            end
            clfr_pkg::ST_FWD_ESC_REQ: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = clfr_pkg::RS_POS;
                state_next = clfr_pkg::ST_FWD_ESC_EVAL;
            end
            clfr_pkg::ST_FWD_ESC_EVAL: begin
                if (status.rdata_is_end) begin
                    cmd.pos_op   = clfr_pkg::PO_INC;
                    cmd.steps_op = clfr_pkg::SO_INC;
                    state_next   = clfr_pkg::ST_FWD_REQ;
                end else begin
                    state_next = clfr_pkg::ST_FWD_DONE;
                end
            end
            clfr_pkg::ST_FWD_DONE: begin
                cmd.pos_op      = clfr_pkg::PO_DEC;
                cmd.set_end_pos = 1'b1;
                cmd.steps_op    = clfr_pkg::SO_ZERO;
                state_next      = clfr_pkg::ST_BWD_REQ;
            end
            clfr_pkg::ST_BWD_REQ: begin
                if (status.steps_gt_m) begin
                    cmd.set_fail = 1'b1;
                    state_next   = clfr_pkg::ST_FIN;
                end else begin
                    // step back and fetch the byte at the new position
                    cmd.steps_op = clfr_pkg::SO_INC;
                    cmd.pos_op   = clfr_pkg::PO_DEC;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = clfr_pkg::RS_POS_DEC;
                    state_next   = clfr_pkg::ST_BWD_EVAL;
                end
            end
            clfr_pkg::ST_BWD_EVAL: begin
                state_next = status.rdata_is_begin ? clfr_pkg::ST_BWD_ESC_REQ
                                                   : clfr_pkg::ST_BWD_REQ;
            end
            clfr_pkg::ST_BWD_ESC_REQ: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = clfr_pkg::RS_POS_DEC;
                state_next = clfr_pkg::ST_BWD_ESC_EVAL;
            end
            clfr_pkg::ST_BWD_ESC_EVAL: begin
                if (status.rdata_is_begin) begin
                    cmd.pos_op   = clfr_pkg::PO_DEC;
                    cmd.steps_op = clfr_pkg::SO_INC;
                    state_next   = clfr_pkg::ST_BWD_REQ;
                end else begin
                    cmd.set_found = 1'b1;
                    state_next    = clfr_pkg::ST_FIN;
                end
            end
            clfr_pkg::ST_RD_REQ: begin
                if (status.rpos_eq_end) begin
                    cmd.res_load_eq = 1'b1;
                    state_next      = clfr_pkg::ST_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = clfr_pkg::RS_RPOS;
                    state_next = clfr_pkg::ST_RD_EVAL;
                end
            end
            clfr_pkg::ST_RD_EVAL: begin
                cmd.save_byte = 1'b1;
                cmd.rpos_inc  = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = clfr_pkg::RS_RPOS_INC;
                state_next    = clfr_pkg::ST_RD_ESC;
            end
            clfr_pkg::ST_RD_ESC: begin
                cmd.rpos_inc      = status.esc_match;
                cmd.res_load_byte = 1'b1;
                state_next        = clfr_pkg::ST_RESP;
            end
            clfr_pkg::ST_FIN: begin
                cmd.res_load_eq = 1'b1;
                state_next      = clfr_pkg::ST_RESP;
            end
            clfr_pkg::ST_RESP: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = clfr_pkg::ST_IDLE;
                end
            end
            default: state_next = clfr_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/circular_log_frame_reader_top.sv
// Top level of the circular log frame reader: controller plus datapath.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_func, s_addr, s_wdata
//  m_        out        m_valid/m_ready    m_data, m_at_end, m_start_position
//  cfg_      in         cfg_we (no wait)   cfg_index, cfg_wdata
//
// One request is in work at a time; the single image memory port (one read
// per cycle, registered) sets the pace. When MEM_SIZE is below 1024, a write
// first subtracts MEM_SIZE from its address until it is in range. A read at
// the end of the record reads no byte from memory. An open reads each byte it
// examines through the same port, scanning forward from position 0, then back.
// The next request is taken the cycle after the result is loaded, even while
// that result still waits for m_ready; the result register holds it stable.
// Reset (aresetn low, synchronous) clears record positions, marks and handshake
// state; the image memory holds no reset and must be written before use.
module circular_log_frame_reader_top #(
    parameter int MEM_SIZE = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [9:0] s_addr,
    input  logic [7:0] s_wdata,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data,
    output logic       m_at_end,
    output logic [9:0] m_start_position
);

    clfr_pkg::dp_cmd_t    cmd;
    clfr_pkg::dp_status_t status;

    // Sequence each request through the scan and read states
    clfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the image, the positions and the result register
    clfr_dpath #(
        .MEM_SIZE (MEM_SIZE)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_addr           (s_addr),
        .s_wdata          (s_wdata),
        .cmd              (cmd),
        .status           (status),
        .m_data           (m_data),
        .m_at_end         (m_at_end),
        .m_start_position (m_start_position)
    );

    // One request at a time: no accept right after an accept
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in work");

    // Load the result register only when it is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result overwritten before it was taken");

    // A loaded result shows up as valid in the next cycle
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

endmodule

FILE: bench/circular_log_frame_reader_checker.sv
// Checker for the circular log frame reader: predicts every result and compares it.
`timescale 1ns / 100ps
module circular_log_frame_reader_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [9:0] s_addr,
    input  logic [7:0] s_wdata,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_data,
    input  logic       m_at_end,
    input  logic [9:0] m_start_position,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    localparam int RING = 1024;

    typedef struct packed {
        logic [7:0] data;
        logic       at_end;
        logic [9:0] start;
    } frame_result_t;

    // Own copy of the block state; 10-bit positions wrap around the ring.
    logic [7:0]    image_copy [RING];
    logic [9:0]    rd_pos;
    logic [9:0]    stop_pos;
    logic [9:0]    mark_pos;
    logic [7:0]    open_mark;
    logic [7:0]    close_mark;
    frame_result_t result_q [$];
    frame_result_t want;

    // Find the record: skip leading end marks, scan forward for a lone end
    // mark, then back for a lone begin mark.
    function automatic void locate_frame();
        logic [9:0] pos;
        logic [9:0] prev;
        logic [9:0] hit;
        logic [7:0] b;
        logic       done;
        int         steps;
        pos = '0;
        steps = 0;
        while (steps < RING && image_copy[pos] == close_mark) begin
            pos = pos + 10'd1;
            steps++;
        end
        steps = 0;
        done = 1'b0;
        while (!done && steps <= RING) begin
            b = image_copy[pos];
            steps++;
            pos = pos + 10'd1;
            if (b == close_mark) begin
                if (image_copy[pos] == close_mark) begin
                    pos = pos + 10'd1;
                    steps++;
                end else begin
                    done = 1'b1;
                end
            end
        end
        pos = pos - 10'd1;
        stop_pos = pos;
        steps = 0;
        done = 1'b0;
        hit = '0;
        while (!done && steps <= RING) begin
            steps++;
            pos = pos - 10'd1;
            prev = pos - 10'd1;
            if (image_copy[pos] == open_mark) begin
                if (image_copy[prev] == open_mark) begin
                    pos = prev;
                    steps++;
                end else begin
                    hit = pos;
                    done = 1'b1;
                end
            end
        end
        mark_pos = hit;
        rd_pos = hit + 10'd1;
    endfunction

    function automatic frame_result_t predict(input logic [1:0] func, input logic [9:0] addr,
                                              input logic [7:0] wdata);
        frame_result_t r;
        logic [7:0]    b;
        r.data = '0;
        if (func == clfr_pkg::FUNC_READ) begin
            r.at_end = (rd_pos == stop_pos);
            if (!r.at_end) begin
                b = image_copy[rd_pos];
                rd_pos = rd_pos + 10'd1;
                // a doubled mark comes out once
                if ((b == open_mark && image_copy[rd_pos] == open_mark) ||
                    (b == close_mark && image_copy[rd_pos] == close_mark))
                    rd_pos = rd_pos + 10'd1;
                r.data = b;
            end
        end else begin
            if (func == clfr_pkg::FUNC_WRITE)
                image_copy[addr] = wdata;
            else if (func == clfr_pkg::FUNC_OPEN)
                locate_frame();
            r.at_end = (rd_pos == stop_pos);
        end
        r.start = mark_pos;
        return r;
    endfunction

    task automatic flag(input string what, input logic [9:0] expv, input logic [9:0] got);
        fail_count++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, expv, got);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            result_q.delete();
            rd_pos = '0;
            stop_pos = '0;
            mark_pos = '0;
            open_mark = clfr_pkg::BEGIN_MARK_RST;
            close_mark = clfr_pkg::END_MARK_RST;
            fail_count = 0;
            checked = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == clfr_pkg::REG_BEGIN_MARK)
                    open_mark = cfg_wdata;
                else
                    close_mark = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no request waiting: expected none, %s",
                             $time, $sformatf("got %0d %0b %0d",
                                              m_data, m_at_end, m_start_position));
                end else begin
                    want = result_q.pop_front();
                    checked++;
                    if (m_data !== want.data)
                        flag("data", 10'(want.data), 10'(m_data));
                    if (m_at_end !== want.at_end)
                        flag("at_end", 10'(want.at_end), 10'(m_at_end));
                    if (m_start_position !== want.start)
                        flag("start_position", want.start, m_start_position);
                end
            end
            if (s_valid && s_ready)
                result_q.push_back(predict(s_func, s_addr, s_wdata));
            pending = result_q.size();
        end
    end

endmodule

FILE: bench/circular_log_frame_reader_top_test.sv
// Top of the frame reader bench: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 100ps
module circular_log_frame_reader_top_test;

    localparam int RING = 1024;
    localparam int RANDOM_ITEMS = 1000;
    // Long enough for the slowest open, with room to spare, with no handshake.
    localparam int STALL_LIMIT = 40000;
    localparam int SETTLE = 16;
    // The fourth request code has no name in the package; the block ignores it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = clfr_pkg::REG_BEGIN_MARK;
    logic [7:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_func = clfr_pkg::FUNC_WRITE;
    logic [9:0] s_addr = '0;
    logic [7:0] s_wdata = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data;
    logic       m_at_end;
    logic [9:0] m_start_position;

    int fail_count;
    int pending;
    int checked;

    // Full-rate stretches: no sender gaps and no receiver stalls while set.
    logic steady = 1'b0;
    int   ready_left = 0;
    int   idle_cycles = 0;
    int   n_sent = 0;
    int   n_write = 0;
    int   n_open = 0;
    int   n_read = 0;
    int   n_other = 0;
    int   n_settings = 0;

    // Marks currently programmed, used to build framed records.
    logic [7:0] cur_begin = clfr_pkg::BEGIN_MARK_RST;
    logic [7:0] cur_end = clfr_pkg::END_MARK_RST;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    circular_log_frame_reader_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_addr           (s_addr),
        .s_wdata          (s_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .m_at_end         (m_at_end),
        .m_start_position (m_start_position)
    );

    circular_log_frame_reader_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_addr           (s_addr),
        .s_wdata          (s_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .m_at_end         (m_at_end),
        .m_start_position (m_start_position),
        .fail_count       (fail_count),
        .pending          (pending),
        .checked          (checked)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [9:0] rand_addr();
        return 10'($urandom_range(0, RING - 1));
    endfunction

    // Any byte that is neither mark, so it cannot frame anything.
    function automatic logic [7:0] pick_filler();
        logic [7:0] v;
        do v = rand_byte(); while (v == cur_begin || v == cur_end);
        return v;
    endfunction

    // Receiver: alternate runs of ready with stalls, both of random length.
    always @(negedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else begin
            m_ready <= !m_ready;
            ready_left = m_ready ? pick_gap() : $urandom_range(0, 12);
        end
    end

    // Watchdog: end the run if no request or result moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog: nothing moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request, hold it until accepted, then maybe drop valid for a gap.
    task automatic send_req(input logic [1:0] func, input logic [9:0] addr,
                            input logic [7:0] wdata);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_func <= func;
        s_addr <= addr;
        s_wdata <= wdata;
        do @(posedge aclk); while (!s_ready);
        case (func)
            clfr_pkg::FUNC_WRITE: n_write++;
            clfr_pkg::FUNC_OPEN:  n_open++;
            clfr_pkg::FUNC_READ:  n_read++;
            default:              n_other++;
        endcase
        n_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Program both marks while the block is idle.
    task automatic set_marks(input logic [7:0] bm, input logic [7:0] em);
        drain();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= clfr_pkg::REG_BEGIN_MARK;
        cfg_wdata <= bm;
        @(negedge aclk);
        cfg_index <= clfr_pkg::REG_END_MARK;
        cfg_wdata <= em;
        @(negedge aclk);
        cfg_we <= 1'b0;
        cur_begin = bm;
        cur_end = em;
        n_settings++;
    endtask

    // Reads carry random, ignored addr and wdata so those bits toggle too.
    task automatic read_bytes(input int count);
        repeat (count) send_req(clfr_pkg::FUNC_READ, rand_addr(), rand_byte());
    endtask

    task automatic send_open();
        send_req(clfr_pkg::FUNC_OPEN, rand_addr(), rand_byte());
    endtask

    // Write a framed record near the ring start, open it and read it back.
    // A few records lose a mark or an escape half on purpose.
    task automatic send_frame();
        int         lead;
        int         span;
        int         len;
        int         k;
        logic [9:0] pos;
        logic [7:0] b;
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        span = lead + $urandom_range(0, 6);
        pos = '0;
        // leading end marks first, then plain bytes up to the begin mark
        for (k = 0; k < span; k++) begin
            send_req(clfr_pkg::FUNC_WRITE, pos, (k < lead) ? cur_end : pick_filler());
            pos = pos + 10'd1;
        end
        if ($urandom_range(0, 15) != 0) begin
            send_req(clfr_pkg::FUNC_WRITE, pos, cur_begin);
            pos = pos + 10'd1;
        end
        len = $urandom_range(0, 10);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0)
                b = $urandom_range(0, 1) ? cur_begin : cur_end;
            else
                b = rand_byte();
            send_req(clfr_pkg::FUNC_WRITE, pos, b);
            pos = pos + 10'd1;
            // escape a mark inside the payload by doubling it, most of the time
            if ((b == cur_begin || b == cur_end) && $urandom_range(0, 7) != 0) begin
                send_req(clfr_pkg::FUNC_WRITE, pos, b);
                pos = pos + 10'd1;
            end
        end
        if ($urandom_range(0, 15) != 0) begin
            send_req(clfr_pkg::FUNC_WRITE, pos, cur_end);
            pos = pos + 10'd1;
        end
        // terminate so old bytes cannot turn the end mark into an escape
        send_req(clfr_pkg::FUNC_WRITE, pos, pick_filler());
        send_open();
        read_bytes(len + $urandom_range(1, 4));
    endtask

    // Sprinkle marks over the low region, open, maybe disturb, read.
    task automatic send_mark_soup();
        int r;
        repeat ($urandom_range(2, 8)) begin
            r = $urandom_range(0, 2);
            send_req(clfr_pkg::FUNC_WRITE, 10'($urandom_range(0, 40)),
                     (r == 0) ? cur_begin : ((r == 1) ? cur_end : rand_byte()));
        end
        send_open();
        // a write after the open can put an escape pair across the end position
        if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 1);
            send_req(clfr_pkg::FUNC_WRITE, 10'($urandom_range(0, 40)),
                     r ? cur_begin : cur_end);
        end
        read_bytes($urandom_range(1, 8));
    endtask

    initial begin : stimulus
        int         i;
        int         goal;
        int         next_switch;
        int         phase;
        int         pick;
        logic [7:0] m;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Read at reset: read and end positions are both zero, so at end.
        send_req(clfr_pkg::FUNC_READ, 10'h3FF, 8'hFF);
        // The unused code is ignored and answers like a write.
        send_req(FUNC_UNUSED, 10'h3FF, 8'hFF);

        // Load the whole image so no open or read can touch an unwritten byte.
        for (i = 0; i < RING; i++)
            send_req(clfr_pkg::FUNC_WRITE, 10'(i), 8'h00);

        // Whole image made of end marks: the leading skip wraps once.
        set_marks(clfr_pkg::BEGIN_MARK_RST, 8'h00);
        send_open();
        read_bytes(2);

        // No end mark and no begin mark anywhere: start falls back to zero.
        set_marks(clfr_pkg::BEGIN_MARK_RST, clfr_pkg::END_MARK_RST);
        send_open();
        read_bytes(2);

        // Leading end marks, then a record with an escaped end mark inside.
        send_req(clfr_pkg::FUNC_WRITE, 10'd0, 8'hFF);
        send_req(clfr_pkg::FUNC_WRITE, 10'd1, 8'hFF);
        send_req(clfr_pkg::FUNC_WRITE, 10'd2, 8'hFE);
        send_req(clfr_pkg::FUNC_WRITE, 10'd3, 8'hA5);
        send_req(clfr_pkg::FUNC_WRITE, 10'd4, 8'hFF);
        send_req(clfr_pkg::FUNC_WRITE, 10'd5, 8'hFF);
        send_req(clfr_pkg::FUNC_WRITE, 10'd6, 8'h5A);
        send_req(clfr_pkg::FUNC_WRITE, 10'd7, 8'hFF);
        send_open();
        read_bytes(5);

        // Reopen, then plant a doubled begin mark across the end position
        // so the escape skip steps over it.
        send_open();
        send_req(clfr_pkg::FUNC_WRITE, 10'd6, 8'hFE);
        send_req(clfr_pkg::FUNC_WRITE, 10'd7, 8'hFE);
        read_bytes(4);

        // Record that wraps from the top of the ring back to position 0.
        send_req(clfr_pkg::FUNC_WRITE, 10'd1022, 8'hFE);
        send_req(clfr_pkg::FUNC_WRITE, 10'd1023, 8'h11);
        send_req(clfr_pkg::FUNC_WRITE, 10'd0, 8'h22);
        send_req(clfr_pkg::FUNC_WRITE, 10'd1, 8'hFF);
        send_open();
        read_bytes(3);

        // Random part: mostly well-formed records, the rest noise, across
        // several mark settings including the extremes and equal marks.
        goal = n_sent + RANDOM_ITEMS;
        next_switch = n_sent;
        phase = 0;
        while (n_sent < goal) begin
            if (n_sent >= next_switch) begin
                case (phase)
                    0: set_marks(8'h00, 8'hFF);
                    1: set_marks(8'hFF, 8'h00);
                    2: begin
                        m = rand_byte();
                        set_marks(m, m);
                    end
                    3: set_marks(rand_byte(), rand_byte());
                    default: set_marks(clfr_pkg::BEGIN_MARK_RST, clfr_pkg::END_MARK_RST);
                endcase
                phase++;
                next_switch += RANDOM_ITEMS / 5;
            end
            steady = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame();
            end else if (pick < 68) begin
                send_mark_soup();
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 4))
                    send_req(clfr_pkg::FUNC_WRITE, rand_addr(), rand_byte());
            end else if (pick < 86) begin
                send_open();
            end else if (pick < 95) begin
                read_bytes($urandom_range(1, 6));
            end else begin
                send_req(FUNC_UNUSED, rand_addr(), rand_byte());
            end
            // hold the sender now and then until the result queue is empty
            if ($urandom_range(0, 24) == 0)
                drain();
        end
        steady = 1'b0;
        drain();

        $display("Covered %0d writes, %0d opens, %0d reads, %0d unused-code requests,",
                 n_write, n_open, n_read, n_other);
        $display("%0d mark settings; compared %0d results, %0d mismatches",
                 n_settings, checked, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
